// ----- rtl/core/bic_pkg.sv -----
// Shared types and constants of the bilinear upscaler.
package bic_pkg;

  localparam int IDX_W      = 12;
  localparam int CH_W       = 8;
  localparam int PIX_W      = 3 * CH_W;
  localparam int DIM_W      = 9;
  localparam int SCL_W      = 5;
  localparam int DST_W      = 14;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;
  localparam int QDEPTH     = 4;

  localparam logic REQ_LOAD    = 1'b0;
  localparam logic REQ_COMPUTE = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SRC_WIDTH  = 2'd0,
    CFG_SRC_HEIGHT = 2'd1,
    CFG_SCALE      = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic              req_type;
    logic [IDX_W-1:0]  row;
    logic [IDX_W-1:0]  col;
    logic [CH_W-1:0]   red;
    logic [CH_W-1:0]   green;
    logic [CH_W-1:0]   blue;
  } req_t;

  typedef struct packed {
    logic [DIM_W-1:0] src_w;
    logic [DIM_W-1:0] src_h;
    logic [DST_W-1:0] dst_w;
    logic [DST_W-1:0] dst_h;
  } geom_t;

endpackage

// ----- rtl/core/bilinear_image_upscaler.sv -----
// Bilinear image upscaler top level: configuration, front end, queue and back end.
//
// Usage: configure source_width (index 0), source_height (1) and scale_factor (2)
// through cfg_we_i/cfg_idx_i/cfg_data_i while the block is idle. A request is
// taken when start_i is high and busy_o is low; busy_o stays low, a new request
// may be given every cycle. req_type_i low loads one source pixel into the frame
// store (no result); req_type_i high asks for one destination pixel.
// Each compute request yields one pixel on red_o/green_o/blue_o, marked by a
// one-cycle result_valid_o strobe. The pipelined divider yields one quotient
// bit per stage, QW = FRAC_BITS + min(clog2(max source dimension), 9) bits; the
// four-bank frame store (row/column parity) serves all four neighbors in the same
// cycle, so throughput is one request per cycle. Loads and computes stay in
// order, so a compute sees every load transferred before it. Reset clears the
// pipeline and sets the configuration registers to 1; the frame store is not
// cleared and must be loaded before it is read. The receiver cannot stall.
module bilinear_image_upscaler import bic_pkg::*; #(
  parameter int MAX_SRC_WIDTH  = 256,
  parameter int MAX_SRC_HEIGHT = 256,
  parameter int FRAC_BITS      = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  start_i,
  output logic                  busy_o,
  input  logic                  req_type_i,
  input  logic [IDX_W-1:0]      row_index_i,
  input  logic [IDX_W-1:0]      col_index_i,
  input  logic [CH_W-1:0]       red_in_i,
  input  logic [CH_W-1:0]       green_in_i,
  input  logic [CH_W-1:0]       blue_in_i,
  output logic                  result_valid_o,
  output logic [CH_W-1:0]       red_out_o,
  output logic [CH_W-1:0]       green_out_o,
  output logic [CH_W-1:0]       blue_out_o
);

  localparam int CW  = $clog2(MAX_SRC_WIDTH);
  localparam int RW  = $clog2(MAX_SRC_HEIGHT);
  localparam int MW  = (CW > RW) ? CW : RW;
  localparam int PW  = (MW < DIM_W) ? MW : DIM_W;
  localparam int QW  = PW + FRAC_BITS;
  localparam int QEW = $bits(req_t) + 2 * RW + 2 * CW + 2 * (FRAC_BITS + 1);
  localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

  // configuration
  logic [DIM_W-1:0] src_w_q, src_h_q;
  logic [SCL_W-1:0] scale_q;
  geom_t            geom;
  logic [DIM_W-1:0] dim_in;

  always_comb begin
    dim_in = cfg_data_i;
    if (cfg_data_i == '0) dim_in = DIM_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_w_q <= DIM_W'(1);
      src_h_q <= DIM_W'(1);
      scale_q <= SCL_W'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SRC_WIDTH:  src_w_q <= (int'(dim_in) > MAX_SRC_WIDTH) ? DIM_W'(MAX_SRC_WIDTH) : dim_in;
        CFG_SRC_HEIGHT: src_h_q <= (int'(dim_in) > MAX_SRC_HEIGHT) ? DIM_W'(MAX_SRC_HEIGHT) : dim_in;
        CFG_SCALE:      scale_q <= (cfg_data_i[SCL_W-1:0] == '0) ? SCL_W'(1) : cfg_data_i[SCL_W-1:0];
        default: ;
      endcase
    end
  end

  // destination sizes follow the registers directly, so a request right after a write sees them
  always_comb begin
    geom.src_w = src_w_q;
    geom.src_h = src_h_q;
    geom.dst_w = DST_W'(src_w_q) * DST_W'(scale_q);
    geom.dst_h = DST_W'(src_h_q) * DST_W'(scale_q);
  end

  assign busy_o = 1'b0;

  req_t in_req;
  assign in_req = '{req_type: req_type_i, row: row_index_i, col: col_index_i,
                    red: red_in_i, green: green_in_i, blue: blue_in_i};

  logic               f_v;
  req_t               f_req;
  logic [RW-1:0]      f_h0, f_h1;
  logic [CW-1:0]      f_w0, f_w1;
  logic [FRAC_BITS:0] f_u, f_t;

  bic_front #(
    .RW (RW), .CW (CW), .PW (PW), .FRAC_BITS (FRAC_BITS), .QW (QW)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (start_i && !busy_o),
    .in_req_i    (in_req),
    .geom_i      (geom),
    .out_valid_o (f_v),
    .out_req_o   (f_req),
    .h0_o        (f_h0),
    .h1_o        (f_h1),
    .w0_o        (f_w0),
    .w1_o        (f_w1),
    .u_o         (f_u),
    .t_o         (f_t)
  );

  logic [QEW-1:0]     q_out;
  logic               q_empty, q_full, p_v;
  req_t               p_req;
  logic [RW-1:0]      p_h0, p_h1;
  logic [CW-1:0]      p_w0, p_w1;
  logic [FRAC_BITS:0] p_u, p_t;

  bic_queue #(.W (QEW), .DEPTH (QDEPTH)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_v),
    .data_i  ({f_req, f_h0, f_h1, f_w0, f_w1, f_u, f_t}),
    .pop_i   (!q_empty),
    .data_o  (q_out),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  assign p_v = !q_empty;
  assign {p_req, p_h0, p_h1, p_w0, p_w1, p_u, p_t} = q_out;

  bic_back #(
    .MAX_SRC_WIDTH (MAX_SRC_WIDTH), .MAX_SRC_HEIGHT (MAX_SRC_HEIGHT),
    .RW (RW), .CW (CW), .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (p_v),
    .in_req_i    (p_req),
    .h0_i        (p_h0),
    .h1_i        (p_h1),
    .w0_i        (p_w0),
    .w1_i        (p_w1),
    .u_i         (p_u),
    .t_i         (p_t),
    .out_valid_o (result_valid_o),
    .red_o       (red_out_o),
    .green_o     (green_out_o),
    .blue_o      (blue_out_o)
  );

  // back end drains every cycle, so the queue never fills
  a_queue_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(f_v && q_full))
    else $error("queue overflow");

  // a result strobe only follows a compute transfer leaving the queue
  a_result_from_compute: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(p_v && p_req.req_type == REQ_COMPUTE, 4))
    else $error("result without compute");

  a_frac_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (p_v && p_req.req_type == REQ_COMPUTE) |-> (p_u <= ONE && p_t <= ONE))
    else $error("fraction above one");

  a_neighbors: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (p_v && p_req.req_type == REQ_COMPUTE) |->
      ((p_h1 == p_h0 + 1'b1 || (p_h0 == '0 && p_h1 == '0)) &&
       (p_w1 == p_w0 + 1'b1 || (p_w0 == '0 && p_w1 == '0))))
    else $error("neighbor indexes inconsistent");

endmodule

// ----- rtl/core/bic_div.sv -----
// Two-lane pipelined restoring divider, one quotient bit per stage.
module bic_div import bic_pkg::*; #(
  parameter int PW        = 8,
  parameter int FRAC_BITS = 16,
  parameter int QW        = 24,
  parameter int SIDE_W    = 1
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  input  logic [1:0][IDX_W+PW-1:0]         in_num_i,
  input  logic [1:0][DST_W-1:0]            den_i,
  input  logic [SIDE_W-1:0]                in_side_i,
  output logic                             out_valid_o,
  output logic [1:0][QW-1:0]               out_quo_o,
  output logic [SIDE_W-1:0]                out_side_o
);

  logic              v_q    [QW+1];
  logic [DST_W-1:0]  rem_q  [QW+1][2];
  logic [PW-1:0]     lo_q   [QW+1][2];
  logic [QW-1:0]     quo_q  [QW+1][2];
  logic [SIDE_W-1:0] side_q [QW+1];

  // stage 0: numerator high part is the starting remainder (it is below the divisor)
  assign v_q[0]    = in_valid_i;
  assign side_q[0] = in_side_i;
  for (genvar a = 0; a < 2; a++) begin : g_in
    assign rem_q[0][a] = DST_W'(in_num_i[a] >> PW);
    assign lo_q[0][a]  = in_num_i[a][PW-1:0];
    assign quo_q[0][a] = '0;
  end

  for (genvar i = 0; i < QW; i++) begin : g_stg
    localparam int K = QW - 1 - i;
    logic [1:0]        sbit;
    logic [DST_W:0]    trial [2];
    logic [1:0]        ge;

    for (genvar a = 0; a < 2; a++) begin : g_lane
      if (K >= FRAC_BITS) begin : g_num
        assign sbit[a] = lo_q[i][a][K-FRAC_BITS];
      end else begin : g_zero
        assign sbit[a] = 1'b0;
      end
      assign trial[a] = {rem_q[i][a], sbit[a]};
      assign ge[a]    = trial[a] >= {1'b0, den_i[a]};

      always_ff @(posedge clk_i) begin
        rem_q[i+1][a] <= ge[a] ? DST_W'(trial[a] - {1'b0, den_i[a]})
                               : trial[a][DST_W-1:0];
        quo_q[i+1][a] <= {quo_q[i][a][QW-2:0], ge[a]};
        lo_q[i+1][a]  <= lo_q[i][a];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i+1] <= 1'b0;
      end else begin
        v_q[i+1] <= v_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      side_q[i+1] <= side_q[i];
    end
  end

  assign out_valid_o  = v_q[QW];
  assign out_side_o   = side_q[QW];
  assign out_quo_o[0] = quo_q[QW][0];
  assign out_quo_o[1] = quo_q[QW][1];

endmodule

// ----- rtl/core/bic_front.sv -----
// Front end: takes requests, clamps indexes, maps them to source base and fraction.
module bic_front import bic_pkg::*; #(
  parameter int RW        = 8,
  parameter int CW        = 8,
  parameter int PW        = 8,
  parameter int FRAC_BITS = 16,
  parameter int QW        = 24
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  req_t               in_req_i,
  input  geom_t              geom_i,
  output logic               out_valid_o,
  output req_t               out_req_o,
  output logic [RW-1:0]      h0_o,
  output logic [RW-1:0]      h1_o,
  output logic [CW-1:0]      w0_o,
  output logic [CW-1:0]      w1_o,
  output logic [FRAC_BITS:0] u_o,
  output logic [FRAC_BITS:0] t_o
);

  localparam int NUMW = IDX_W + PW;
  localparam int PRW  = IDX_W + DIM_W;

  // stage A: clamp destination indexes to dst-1
  logic             a_v_q;
  req_t             a_req_q;
  logic [IDX_W-1:0] a_ridx_q, a_cidx_q;
  logic [IDX_W-1:0] ridx, cidx;

  always_comb begin
    ridx = in_req_i.row;
    cidx = in_req_i.col;
    if (DST_W'(in_req_i.row) >= geom_i.dst_h) ridx = IDX_W'(geom_i.dst_h - 1'b1);
    if (DST_W'(in_req_i.col) >= geom_i.dst_w) cidx = IDX_W'(geom_i.dst_w - 1'b1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
    end else begin
      a_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    a_req_q  <= in_req_i;
    a_ridx_q <= ridx;
    a_cidx_q <= cidx;
  end

  // stage B: numerators idx*(src-1)
  logic                 b_v_q;
  req_t                 b_req_q;
  logic [1:0][NUMW-1:0] b_num_q;
  logic [PRW-1:0]       prod_r, prod_c;

  assign prod_r = {{DIM_W{1'b0}}, a_ridx_q} * {{IDX_W{1'b0}}, geom_i.src_h - 1'b1};
  assign prod_c = {{DIM_W{1'b0}}, a_cidx_q} * {{IDX_W{1'b0}}, geom_i.src_w - 1'b1};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_v_q <= 1'b0;
    end else begin
      b_v_q <= a_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    b_req_q    <= a_req_q;
    b_num_q[0] <= NUMW'(prod_r);
    b_num_q[1] <= NUMW'(prod_c);
  end

  logic [1:0][DST_W-1:0] den;
  logic                  d_v;
  logic [1:0][QW-1:0]    d_quo;
  req_t                  d_req;

  assign den[0] = geom_i.dst_h - 1'b1;
  assign den[1] = geom_i.dst_w - 1'b1;

  bic_div #(
    .PW        (PW),
    .FRAC_BITS (FRAC_BITS),
    .QW        (QW),
    .SIDE_W    ($bits(req_t))
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (b_v_q),
    .in_num_i    (b_num_q),
    .den_i       (den),
    .in_side_i   (b_req_q),
    .out_valid_o (d_v),
    .out_quo_o   (d_quo),
    .out_side_o  (d_req)
  );

  // floor, clamp base to src-2, fraction may reach one
  logic [DIM_W-1:0]   src   [2];
  logic [PW-1:0]      base  [2];
  logic [PW:0]        nxt   [2];
  logic [FRAC_BITS:0] frac  [2];
  logic [QW:0]        fdiff [2];

  assign src[0] = geom_i.src_h;
  assign src[1] = geom_i.src_w;

  always_comb begin
    for (int a = 0; a < 2; a++) begin
      base[a] = d_quo[a][QW-1:FRAC_BITS];
      if ((DIM_W+1)'(base[a]) >= (DIM_W+1)'(src[a]) - (DIM_W+1)'(1)) begin
        base[a] = PW'(src[a] - 2'd2);
      end
      fdiff[a] = {1'b0, d_quo[a]} - {1'b0, base[a], {FRAC_BITS{1'b0}}};
      frac[a]  = fdiff[a][FRAC_BITS:0];
      nxt[a]   = {1'b0, base[a]} + 1'b1;
      if (src[a] == DIM_W'(1)) begin
        base[a] = '0;
        nxt[a]  = '0;
        frac[a] = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else begin
      out_valid_o <= d_v;
    end
  end

  always_ff @(posedge clk_i) begin
    out_req_o <= d_req;
    h0_o      <= RW'(base[0]);
    h1_o      <= RW'(nxt[0]);
    w0_o      <= CW'(base[1]);
    w1_o      <= CW'(nxt[1]);
    u_o       <= frac[0];
    t_o       <= frac[1];
  end

endmodule

// ----- rtl/core/bic_queue.sv -----
// Small FIFO between front end and back end.
module bic_queue #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] data_i,
  input  logic         pop_i,
  output logic [W-1:0] data_o,
  output logic         empty_o,
  output logic         full_o
);

  localparam int AW = $clog2(DEPTH);

  logic [W-1:0] mem_q [DEPTH];
  logic [AW-1:0] wr_q, rd_q;
  logic [AW:0]   cnt_q;
  logic          do_push, do_pop;

  assign empty_o = cnt_q == '0;
  assign full_o  = cnt_q == (AW+1)'(DEPTH);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= (wr_q == AW'(DEPTH-1)) ? '0 : wr_q + 1'b1;
      if (do_pop)  rd_q <= (rd_q == AW'(DEPTH-1)) ? '0 : rd_q + 1'b1;
      cnt_q <= cnt_q + (AW+1)'(do_push) - (AW+1)'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= data_i;
  end

endmodule

// ----- rtl/core/bic_back.sv -----
// Back end: four-bank frame store, neighbor fetch and bilinear blend.
module bic_back import bic_pkg::*; #(
  parameter int MAX_SRC_WIDTH  = 256,
  parameter int MAX_SRC_HEIGHT = 256,
  parameter int RW             = 8,
  parameter int CW             = 8,
  parameter int FRAC_BITS      = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  req_t               in_req_i,
  input  logic [RW-1:0]      h0_i,
  input  logic [RW-1:0]      h1_i,
  input  logic [CW-1:0]      w0_i,
  input  logic [CW-1:0]      w1_i,
  input  logic [FRAC_BITS:0] u_i,
  input  logic [FRAC_BITS:0] t_i,
  output logic               out_valid_o,
  output logic [CH_W-1:0]    red_o,
  output logic [CH_W-1:0]    green_o,
  output logic [CH_W-1:0]    blue_o
);

  localparam int RHW = (RW > 1) ? RW - 1 : 1;
  localparam int CHW = (CW > 1) ? CW - 1 : 1;
  localparam int BAW = RHW + CHW;
  localparam int WW  = 2 * FRAC_BITS + 1;
  localparam int PRW = WW + CH_W;
  localparam int SMW = PRW + 2;
  localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

  // stage 0: bank select by row/column parity, so the four neighbors hit four banks
  logic             is_load, is_cmp, wr_ok;
  logic [1:0]       wbank;
  logic [BAW-1:0]   waddr;
  logic [BAW-1:0]   raddr [4];
  logic [3:0]       we;
  logic [PIX_W-1:0] wdata;
  logic [PIX_W-1:0] rd_q  [4];

  assign is_load = in_valid_i && (in_req_i.req_type == REQ_LOAD);
  assign is_cmp  = in_valid_i && (in_req_i.req_type == REQ_COMPUTE);
  assign wr_ok   = (int'(in_req_i.row) < MAX_SRC_HEIGHT) && (int'(in_req_i.col) < MAX_SRC_WIDTH);
  assign wbank   = {in_req_i.row[0], in_req_i.col[0]};
  assign waddr   = {RHW'(in_req_i.row >> 1), CHW'(in_req_i.col >> 1)};
  assign wdata   = {in_req_i.red, in_req_i.green, in_req_i.blue};

  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic [RW-1:0]  rsel;
    logic [CW-1:0]  csel;
    logic [PIX_W-1:0] mem [2**BAW];

    assign rsel     = (h0_i[0] == b[1]) ? h0_i : h1_i;
    assign csel     = (w0_i[0] == b[0]) ? w0_i : w1_i;
    assign raddr[b] = {RHW'(rsel >> 1), CHW'(csel >> 1)};
    assign we[b]    = is_load && wr_ok && (wbank == 2'(b));

    always_ff @(posedge clk_i) begin
      if (we[b]) mem[waddr] <= wdata;
      rd_q[b] <= mem[raddr[b]];
    end
  end

  // stage 1
  logic               s1_v_q, s1_hp_q, s1_wp_q, s1_hs_q, s1_ws_q;
  logic [FRAC_BITS:0] s1_u_q, s1_t_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else begin
      s1_v_q <= is_cmp;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_hp_q <= h0_i[0];
    s1_wp_q <= w0_i[0];
    s1_hs_q <= (h0_i == h1_i);
    s1_ws_q <= (w0_i == w1_i);
    s1_u_q  <= u_i;
    s1_t_q  <= t_i;
  end

  // stage 2: reorder banks into neighbors 00, 01, 11, 10 and form weights
  logic               s2_v_q;
  logic [PIX_W-1:0]   s2_px_q [4];
  logic [WW-1:0]      s2_wt_q [4];
  logic [FRAC_BITS:0] omt, omu;
  logic               hn, wn;

  assign omt = ONE - s1_t_q;
  assign omu = ONE - s1_u_q;
  // single-pixel axis: the far neighbor is the near one, same bank
  assign hn  = s1_hs_q ? s1_hp_q : ~s1_hp_q;
  assign wn  = s1_ws_q ? s1_wp_q : ~s1_wp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else begin
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_px_q[0] <= rd_q[{s1_hp_q, s1_wp_q}];
    s2_px_q[1] <= rd_q[{s1_hp_q, wn}];
    s2_px_q[2] <= rd_q[{hn, wn}];
    s2_px_q[3] <= rd_q[{hn, s1_wp_q}];
    s2_wt_q[0] <= WW'(omt * omu);
    s2_wt_q[1] <= WW'(s1_t_q * omu);
    s2_wt_q[2] <= WW'(s1_t_q * s1_u_q);
    s2_wt_q[3] <= WW'(omt * s1_u_q);
  end

  // stage 3: per-channel products
  logic           s3_v_q;
  logic [PRW-1:0] s3_pr_q [3][4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_v_q <= 1'b0;
    end else begin
      s3_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int c = 0; c < 3; c++) begin
      for (int k = 0; k < 4; k++) begin
        s3_pr_q[c][k] <= {{WW{1'b0}}, s2_px_q[k][PIX_W-1-CH_W*c -: CH_W]}
                       * {{CH_W{1'b0}}, s2_wt_q[k]};
      end
    end
  end

  // stage 4: sum, truncate, saturate
  logic [SMW-1:0]  sum [3];
  logic [SMW-1:0]  shf [3];
  logic [CH_W-1:0] sat [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      sum[c] = SMW'(s3_pr_q[c][0]) + SMW'(s3_pr_q[c][1])
             + SMW'(s3_pr_q[c][2]) + SMW'(s3_pr_q[c][3]);
      shf[c] = sum[c] >> (2 * FRAC_BITS);
      sat[c] = (shf[c] > SMW'(255)) ? {CH_W{1'b1}} : shf[c][CH_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else begin
      out_valid_o <= s3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    red_o   <= sat[0];
    green_o <= sat[1];
    blue_o  <= sat[2];
  end

endmodule

// ----- tb/bilinear_image_upscaler_test.sv -----
// Self-checking testbench for the bilinear image upscaler: frame loads, pixel computes, checks.
module bilinear_image_upscaler_test;
  import bic_pkg::*;

  localparam int STORE_W   = 256;
  localparam int STORE_H   = 256;
  localparam int FRAC      = 16;
  localparam int LAT_WAIT  = 45;
  localparam int WDOG_MAX  = 3000;

  typedef struct {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } rgb_t;

  // Bilinear predictor plus the queue of pixels still owed by the block.
  class upscale_scoreboard;
    logic [PIX_W-1:0] frame[STORE_W*STORE_H];
    int unsigned      src_w = 1;
    int unsigned      src_h = 1;
    int unsigned      scale = 1;
    rgb_t             owed_pixels[$];
    int               mismatches = 0;

    function void write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] data);
      int unsigned v;
      v = data;
      case (idx)
        CFG_SRC_WIDTH:  src_w = (v == 0) ? 1 : (v > STORE_W) ? STORE_W : v;
        CFG_SRC_HEIGHT: src_h = (v == 0) ? 1 : (v > STORE_H) ? STORE_H : v;
        CFG_SCALE: begin
          v = v & 5'h1f;
          scale = (v == 0) ? 1 : v;
        end
        default: ;
      endcase
    endfunction

    function void map_axis(int unsigned idx_in, int unsigned src, output int unsigned b0,
                           output int unsigned b1, output longint unsigned fr);
      longint unsigned dst, pos, b, idx;
      dst = src * scale;
      idx = idx_in;
      if (idx >= dst) idx = dst - 1;
      b0 = 0;
      b1 = 0;
      fr = 0;
      if (src > 1 && dst > 1) begin
        pos = ((idx * (src - 1)) << FRAC) / (dst - 1);
        b = pos >> FRAC;
        if (b >= src - 1) b = src - 2;
        b0 = b;
        b1 = b + 1;
        fr = pos - (b << FRAC);
      end
    endfunction

    function void note_input(logic rtype, logic [IDX_W-1:0] row, logic [IDX_W-1:0] col,
                             logic [CH_W-1:0] r, logic [CH_W-1:0] g, logic [CH_W-1:0] b);
      int unsigned      h0, h1, w0, w1;
      longint unsigned  t, u, one, acc;
      longint unsigned  wt[4];
      logic [PIX_W-1:0] px[4];
      logic [CH_W-1:0]  ch_val[3];
      rgb_t             p;
      if (rtype == REQ_LOAD) begin
        if (row < STORE_H && col < STORE_W) frame[row*STORE_W + col] = {r, g, b};
        return;
      end
      map_axis(row, src_h, h0, h1, u);
      map_axis(col, src_w, w0, w1, t);
      one = 64'd1 << FRAC;
      px[0] = frame[h0*STORE_W + w0];
      px[1] = frame[h0*STORE_W + w1];
      px[2] = frame[h1*STORE_W + w1];
      px[3] = frame[h1*STORE_W + w0];
      wt[0] = (one - t) * (one - u);
      wt[1] = t * (one - u);
      wt[2] = t * u;
      wt[3] = (one - t) * u;
      for (int ch = 0; ch < 3; ch++) begin
        acc = 0;
        for (int k = 0; k < 4; k++)
          acc += longint'(px[k][(2-ch)*CH_W +: CH_W]) * wt[k];
        acc = acc >> (2*FRAC);
        ch_val[ch] = (acc > 255) ? 8'hff : acc[7:0];
      end
      p.red = ch_val[0];
      p.green = ch_val[1];
      p.blue = ch_val[2];
      owed_pixels.push_back(p);
    endfunction

    function void check_result(logic [CH_W-1:0] r, logic [CH_W-1:0] g, logic [CH_W-1:0] b);
      rgb_t e;
      if (owed_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected pixel %h %h %h", r, g, b);
        return;
      end
      e = owed_pixels.pop_front();
      if (e.red !== r || e.green !== g || e.blue !== b) begin
        mismatches++;
        if (mismatches <= 10)
          $display("pixel mismatch: expected %h %h %h, got %h %h %h",
                   e.red, e.green, e.blue, r, g, b);
      end
    endfunction

    function int pending();
      return owed_pixels.size();
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  start_i = 1'b0;
  logic                  busy_o;
  logic                  req_type_i = 1'b0;
  logic [IDX_W-1:0]      row_index_i = '0;
  logic [IDX_W-1:0]      col_index_i = '0;
  logic [CH_W-1:0]       red_in_i = '0;
  logic [CH_W-1:0]       green_in_i = '0;
  logic [CH_W-1:0]       blue_in_i = '0;
  logic                  result_valid_o;
  logic [CH_W-1:0]       red_out_o;
  logic [CH_W-1:0]       green_out_o;
  logic [CH_W-1:0]       blue_out_o;

  upscale_scoreboard sb = new();
  bit                loaded[STORE_W*STORE_H];
  bit                gaps_on = 1'b1;
  int                quiet_cycles = 0;

  bilinear_image_upscaler u_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i, .start_i, .busy_o,
    .req_type_i, .row_index_i, .col_index_i, .red_in_i, .green_in_i, .blue_in_i,
    .result_valid_o, .red_out_o, .green_out_o, .blue_out_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) sb.check_result(red_out_o, green_out_o, blue_out_o);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || result_valid_o) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WDOG_MAX) begin
      $display("bilinear_image_upscaler_test: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_req(logic rtype, logic [IDX_W-1:0] row, logic [IDX_W-1:0] col,
                          logic [PIX_W-1:0] rgb);
    start_i     <= 1'b1;
    req_type_i  <= rtype;
    row_index_i <= row;
    col_index_i <= col;
    {red_in_i, green_in_i, blue_in_i} <= rgb;
    do @(posedge clk_i); while (busy_o);
    sb.note_input(rtype, row, col, rgb[23:16], rgb[15:8], rgb[7:0]);
    if (rtype == REQ_LOAD && row < STORE_H && col < STORE_W) loaded[row*STORE_W + col] = 1'b1;
    if (gaps_on && $urandom_range(0, 7) == 0) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
  endtask

  // Let every owed pixel drain, then cover the tail of trailing loads.
  task automatic drain();
    start_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (LAT_WAIT) @(posedge clk_i);
  endtask

  // Leaves the write enable high; write_geom drops it once after the last write.
  task automatic write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    sb.write_reg(idx, data);
  endtask

  task automatic write_geom(logic [CFG_DATA_W-1:0] w_raw, logic [CFG_DATA_W-1:0] h_raw,
                            logic [CFG_DATA_W-1:0] s_raw);
    write_reg(CFG_SRC_WIDTH, w_raw);
    write_reg(CFG_SRC_HEIGHT, h_raw);
    write_reg(CFG_SCALE, s_raw);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [IDX_W-1:0] pick_dst(int unsigned dst);
    case ($urandom_range(0, 9))
      0:       return IDX_W'($urandom_range(0, 4095));
      1:       return IDX_W'(dst - 1);
      2:       return '0;
      default: return IDX_W'($urandom_range(0, dst - 1));
    endcase
  endfunction

  task automatic run_phase(logic [CFG_DATA_W-1:0] w_raw, logic [CFG_DATA_W-1:0] h_raw,
                           logic [CFG_DATA_W-1:0] s_raw, int n_computes);
    drain();
    write_geom(w_raw, h_raw, s_raw);
    for (int r = 0; r < sb.src_h; r++)
      for (int c = 0; c < sb.src_w; c++)
        if (!loaded[r*STORE_W + c]) send_req(REQ_LOAD, IDX_W'(r), IDX_W'(c), PIX_W'($urandom));
    for (int i = 0; i < n_computes; i++) begin
      if ($urandom_range(0, 6) == 0) begin
        // stray loads: overwrite inside the image or land anywhere in index space
        if ($urandom_range(0, 1))
          send_req(REQ_LOAD, IDX_W'($urandom_range(0, sb.src_h - 1)),
                   IDX_W'($urandom_range(0, sb.src_w - 1)), PIX_W'($urandom));
        else
          send_req(REQ_LOAD, IDX_W'($urandom_range(0, 4095)), IDX_W'($urandom_range(0, 4095)),
                   PIX_W'($urandom));
      end else begin
        send_req(REQ_COMPUTE, pick_dst(sb.src_h * sb.scale), pick_dst(sb.src_w * sb.scale),
                 PIX_W'($urandom));
      end
    end
  endtask

  initial begin
    int w, h, s;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset geometry is 1x1 at scale 1: plain copy, saturating indices, ignored loads.
    send_req(REQ_LOAD, 0, 0, 24'hffffff);
    send_req(REQ_COMPUTE, 0, 0, 24'h000000);
    send_req(REQ_COMPUTE, 12'hfff, 12'hfff, 24'hffffff);
    send_req(REQ_LOAD, 12'hfff, 12'hfff, 24'h123456);
    send_req(REQ_LOAD, 255, 255, 24'h000000);
    send_req(REQ_LOAD, 256, 0, 24'habcdef);
    send_req(REQ_LOAD, 0, 256, 24'habcdef);
    send_req(REQ_LOAD, 0, 0, 24'h000000);
    send_req(REQ_COMPUTE, 0, 12'hfff, 24'h000000);

    // Fraction reaching one at the far edge.
    drain();
    write_geom(2, 2, 16);
    send_req(REQ_LOAD, 0, 0, 24'hffffff);
    send_req(REQ_LOAD, 0, 1, 24'h000000);
    send_req(REQ_LOAD, 1, 0, 24'h00ff00);
    send_req(REQ_LOAD, 1, 1, 24'hff00ff);
    send_req(REQ_COMPUTE, 31, 31, 24'h0);
    send_req(REQ_COMPUTE, 0, 0, 24'h0);
    send_req(REQ_COMPUTE, 15, 16, 24'h0);
    send_req(REQ_COMPUTE, 30, 1, 24'h0);

    run_phase(2, 2, 16, 120);
    run_phase(9'd300, 1, 9'h1e1, 110);   // width clamps to max, scale masks to 1
    run_phase(0, 256, 2, 110);           // zero width taken as one
    run_phase(3, 5, 9'h100, 100);        // scale field zero taken as one
    run_phase(9'd511, 2, 9'h1f, 40);     // width clamps to max at the widest scale
    for (int p = 0; p < 8; p++) begin
      w = $urandom_range(1, 10);
      h = $urandom_range(1, 10);
      s = $urandom_range(1, 16);
      if (p == 7) gaps_on = 1'b0;
      run_phase(CFG_DATA_W'(w), CFG_DATA_W'(h), CFG_DATA_W'(s), 70);
    end

    drain();
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("bilinear_image_upscaler_test: PASS");
    end else begin
      $display("bilinear_image_upscaler_test: FAIL");
    end
    $finish;
  end

endmodule
